// ===== rtl/shfc_pkg.sv =====
// Package for the site health fault classifier: payload types, output codes, thresholds.
`default_nettype none
package shfc_pkg;

   // Full-scale converter code
   localparam int unsigned FULL_CODE = 4095;

   // Request and response payloads
   typedef struct packed {
      logic [11:0]        bus_voltage_code;
      logic [11:0]        bus_current_code;
      logic [11:0]        battery_code;
      logic [11:0]        forward_code;
      logic [11:0]        reflected_code;
      logic [11:0]        latency_code;
      logic [11:0]        loss_code;
      logic [11:0]        rssi_code;
      logic signed [11:0] amp_temperature;
      logic [15:0]        vibration_level;
      logic [6:0]         status_flags;
   } req_type;

   typedef struct packed {
      logic [2:0] rf_health;
      logic [1:0] electrical_health;
      logic [1:0] backhaul_state;
      logic [1:0] site_status;
      logic [1:0] fault_kind;
      logic [1:0] power_source;
      logic [2:0] energy_action;
   } rsp_type;

   // Status flag bit positions
   localparam int unsigned FLAG_LINK     = 0;
   localparam int unsigned FLAG_UPSTREAM = 1;
   localparam int unsigned FLAG_GRID     = 2;
   localparam int unsigned FLAG_GEN      = 3;
   localparam int unsigned FLAG_FAN      = 4;
   localparam int unsigned FLAG_RECT     = 5;
   localparam int unsigned FLAG_RADIO    = 6;

   // RF health codes
   localparam logic [2:0] RF_EXCELLENT = 3'd0;
   localparam logic [2:0] RF_NORMAL    = 3'd1;
   localparam logic [2:0] RF_DEGRADED  = 3'd2;
   localparam logic [2:0] RF_FAULT     = 3'd3;
   localparam logic [2:0] RF_SEVERE    = 3'd4;

   // Three-level health codes (electrical, site)
   localparam logic [1:0] HLTH_NORMAL   = 2'd0;
   localparam logic [1:0] HLTH_DEGRADED = 2'd1;
   localparam logic [1:0] HLTH_FAULT    = 2'd2;

   // Backhaul codes
   localparam logic [1:0] BH_NORMAL   = 2'd0;
   localparam logic [1:0] BH_DEGRADED = 2'd1;
   localparam logic [1:0] BH_CRITICAL = 2'd2;
   localparam logic [1:0] BH_OUTAGE   = 2'd3;

   // Fault kind codes
   localparam logic [1:0] KIND_NORMAL   = 2'd0;
   localparam logic [1:0] KIND_LOCAL    = 2'd1;
   localparam logic [1:0] KIND_UPSTREAM = 2'd2;
   localparam logic [1:0] KIND_MIXED    = 2'd3;

   // Power source codes
   localparam logic [1:0] SRC_GRID    = 2'd0;
   localparam logic [1:0] SRC_GEN     = 2'd1;
   localparam logic [1:0] SRC_BATTERY = 2'd2;
   localparam logic [1:0] SRC_NONE    = 2'd3;

   // Energy action codes
   localparam logic [2:0] ACT_STOP_GEN   = 3'd0;
   localparam logic [2:0] ACT_NORMAL     = 3'd1;
   localparam logic [2:0] ACT_GEN_SUPPLY = 3'd2;
   localparam logic [2:0] ACT_BATTERY    = 3'd3;
   localparam logic [2:0] ACT_START_GEN  = 3'd4;
   localparam logic [2:0] ACT_SHED       = 3'd5;
   localparam logic [2:0] ACT_CRITICAL   = 3'd6;

   // Bus voltage limits (40/58 V fault, 44/55 V degraded)
   localparam logic [11:0] V_FAULT_LO = 12'd2730;
   localparam logic [11:0] V_FAULT_HI = 12'd3959;
   localparam logic [11:0] V_DEGR_LO  = 12'd3003;
   localparam logic [11:0] V_DEGR_HI  = 12'd3754;
   // Bus current limits (25 A fault, 20 A degraded, 1 A idle, 20 W forward)
   localparam logic [11:0] C_FAULT    = 12'd3413;
   localparam logic [11:0] C_DEGR     = 12'd2730;
   localparam logic [11:0] C_IDLE     = 12'd136;
   localparam logic [11:0] F_ACTIVE   = 12'd819;

   // Bus power limits on the code product: 1200 W and 900 W
   localparam logic [23:0] VC_FAULT = 24'((2 * FULL_CODE * FULL_CODE) / 3);
   localparam logic [23:0] VC_DEGR  = 24'((FULL_CODE * FULL_CODE) / 2);

   // Backhaul limits, rounded up so that code >= limit matches the scaled compare
   localparam logic [11:0] LAT_CRIT   = 12'((590 * FULL_CODE + 989) / 990);
   localparam logic [11:0] LAT_DEGR   = 12'((190 * FULL_CODE + 989) / 990);
   localparam logic [11:0] LOSS_CRIT  = 12'((60 * FULL_CODE + 99) / 100);
   localparam logic [11:0] LOSS_DEGR  = 12'((10 * FULL_CODE + 99) / 100);
   localparam logic [11:0] RSSI_CRIT  = 12'((50 * FULL_CODE + 74) / 75);
   localparam logic [11:0] RSSI_DEGR  = 12'((35 * FULL_CODE + 74) / 75);

   // Battery charge limits, rounded down so that code > limit matches
   localparam logic [11:0] SOC30_LIM = 12'((1116 * FULL_CODE) / 1500);
   localparam logic [11:0] SOC10_LIM = 12'((1072 * FULL_CODE) / 1500);
   localparam logic [11:0] SOC5_LIM  = 12'((1061 * FULL_CODE) / 1500);

   // Amplifier temperature (80 and 65 degC in 1/16 degC) and vibration limits
   localparam logic signed [11:0] TEMP_FAULT = 12'sd1280;
   localparam logic signed [11:0] TEMP_DEGR  = 12'sd1040;
   localparam logic [15:0]        VIB_FAULT  = 16'd768;
   localparam logic [15:0]        VIB_DEGR   = 16'd256;

endpackage
`default_nettype wire

// ===== rtl/site_health_fault_classifier.sv =====
// Site health fault classifier: three-stage pipeline from snapshot to health codes.
// Each request passes the stage 1 and stage 2 registers and then the output register.
// Throughput: one request per cycle; a stage holds only while the next one is full and held.
// Stage 1 does the threshold compares and the bus power multiply, stage 2 the per-domain
// classes, stage 3 the site, fault, source and action decisions into the output register.
// Reset (synchronous, active high) empties all stages; payload registers are not reset.
`default_nettype none
module site_health_fault_classifier (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire shfc_pkg::req_type   req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output shfc_pkg::rsp_type        rsp_data
);
   import shfc_pkg::*;

   // Stage 1 contents: compare results and the voltage-current product
   typedef struct packed {
      logic        rf_invalid;
      logic        rf_lt25;
      logic        rf_lt9;
      logic        rf_lt4;
      logic        v_fault;
      logic        c_fault;
      logic        idle_fault;
      logic        v_degr;
      logic        c_degr;
      logic [23:0] vc;
      logic        link_down;
      logic        bh_crit;
      logic        bh_degr;
      logic        temp_fault;
      logic        temp_degr;
      logic        vib_fault;
      logic        vib_degr;
      logic        soc30;
      logic        soc10;
      logic        soc5;
      logic        grid;
      logic        gen;
      logic        equip_ok;
   } s1_type;

   // Stage 2 contents: domain classes and what the decisions still need
   typedef struct packed {
      logic [2:0] rfh;
      logic [1:0] eh;
      logic [1:0] bh;
      logic       temp_fault;
      logic       temp_degr;
      logic       vib_fault;
      logic       vib_degr;
      logic       soc30;
      logic       soc10;
      logic       soc5;
      logic       grid;
      logic       gen;
      logic       equip_ok;
   } s2_type;

   logic    v1_ff, v2_ff, v3_ff;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   rsp_type s3_ff, s3_in;
   logic    adv1, adv2, adv3;
   logic [16:0] r25, r9, r4, f_ext;

   // Stage advance: a stage loads when it is empty or its content moves on
   assign adv3      = !v3_ff || rsp_ready;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;
   assign rsp_valid = v3_ff;
   assign rsp_data  = s3_ff;

   // Stage 1: scaled reflected power, threshold compares and the bus power product
   assign f_ext = {5'd0, req_data.forward_code};
   assign r25   = 17'(req_data.reflected_code) * 17'd25;
   assign r9    = 17'(req_data.reflected_code) * 17'd9;
   assign r4    = {3'd0, req_data.reflected_code, 2'b00};

   always_comb begin
      s1_in.rf_invalid = (req_data.forward_code == 12'd0) ||
                         (req_data.reflected_code >= req_data.forward_code);
      s1_in.rf_lt25    = r25 < f_ext;
      s1_in.rf_lt9     = r9 < f_ext;
      s1_in.rf_lt4     = r4 < f_ext;
      s1_in.v_fault    = (req_data.bus_voltage_code < V_FAULT_LO) ||
                         (req_data.bus_voltage_code >= V_FAULT_HI);
      s1_in.c_fault    = req_data.bus_current_code >= C_FAULT;
      s1_in.idle_fault = (req_data.forward_code > F_ACTIVE) &&
                         (req_data.bus_current_code <= C_IDLE);
      s1_in.v_degr     = (req_data.bus_voltage_code < V_DEGR_LO) ||
                         (req_data.bus_voltage_code >= V_DEGR_HI);
      s1_in.c_degr     = req_data.bus_current_code > C_DEGR;
      s1_in.vc         = {12'd0, req_data.bus_voltage_code} *
                         {12'd0, req_data.bus_current_code};
      s1_in.link_down  = !req_data.status_flags[FLAG_LINK] ||
                         !req_data.status_flags[FLAG_UPSTREAM];
      s1_in.bh_crit    = (req_data.latency_code >= LAT_CRIT) ||
                         (req_data.loss_code >= LOSS_CRIT) ||
                         (req_data.rssi_code >= RSSI_CRIT);
      s1_in.bh_degr    = (req_data.latency_code >= LAT_DEGR) ||
                         (req_data.loss_code >= LOSS_DEGR) ||
                         (req_data.rssi_code >= RSSI_DEGR);
      s1_in.temp_fault = req_data.amp_temperature >= TEMP_FAULT;
      s1_in.temp_degr  = req_data.amp_temperature >= TEMP_DEGR;
      s1_in.vib_fault  = req_data.vibration_level >= VIB_FAULT;
      s1_in.vib_degr   = req_data.vibration_level >= VIB_DEGR;
      s1_in.soc30      = req_data.battery_code > SOC30_LIM;
      s1_in.soc10      = req_data.battery_code > SOC10_LIM;
      s1_in.soc5       = req_data.battery_code > SOC5_LIM;
      s1_in.grid       = req_data.status_flags[FLAG_GRID];
      s1_in.gen        = req_data.status_flags[FLAG_GEN];
      s1_in.equip_ok   = req_data.status_flags[FLAG_FAN] &&
                         req_data.status_flags[FLAG_RECT] &&
                         req_data.status_flags[FLAG_RADIO];
   end

   // Stage 2: RF, electrical and backhaul classes
   always_comb begin
      s2_in.rfh = RF_FAULT;
      if (s1_ff.rf_invalid) begin
         s2_in.rfh = RF_SEVERE;
      end else if (s1_ff.rf_lt25) begin
         s2_in.rfh = RF_EXCELLENT;
      end else if (s1_ff.rf_lt9) begin
         s2_in.rfh = RF_NORMAL;
      end else if (s1_ff.rf_lt4) begin
         s2_in.rfh = RF_DEGRADED;
      end

      s2_in.eh = HLTH_NORMAL;
      if (s1_ff.v_fault || s1_ff.c_fault || (s1_ff.vc > VC_FAULT) || s1_ff.idle_fault) begin
         s2_in.eh = HLTH_FAULT;
      end else if (s1_ff.v_degr || s1_ff.c_degr || (s1_ff.vc > VC_DEGR)) begin
         s2_in.eh = HLTH_DEGRADED;
      end

      s2_in.bh = BH_NORMAL;
      if (s1_ff.link_down) begin
         s2_in.bh = BH_OUTAGE;
      end else if (s1_ff.bh_crit) begin
         s2_in.bh = BH_CRITICAL;
      end else if (s1_ff.bh_degr) begin
         s2_in.bh = BH_DEGRADED;
      end

      s2_in.temp_fault = s1_ff.temp_fault;
      s2_in.temp_degr  = s1_ff.temp_degr;
      s2_in.vib_fault  = s1_ff.vib_fault;
      s2_in.vib_degr   = s1_ff.vib_degr;
      s2_in.soc30      = s1_ff.soc30;
      s2_in.soc10      = s1_ff.soc10;
      s2_in.soc5       = s1_ff.soc5;
      s2_in.grid       = s1_ff.grid;
      s2_in.gen        = s1_ff.gen;
      s2_in.equip_ok   = s1_ff.equip_ok;
   end

   // Stage 3: site status, fault kind, power source and energy action
   always_comb begin
      s3_in.rf_health         = s2_ff.rfh;
      s3_in.electrical_health = s2_ff.eh;
      s3_in.backhaul_state    = s2_ff.bh;

      // equipment failure overrides everything else
      if (!s2_ff.equip_ok || (s2_ff.rfh >= RF_FAULT) || (s2_ff.eh == HLTH_FAULT) ||
          s2_ff.temp_fault || s2_ff.vib_fault) begin
         s3_in.site_status = HLTH_FAULT;
      end else if ((s2_ff.rfh == RF_DEGRADED) || (s2_ff.eh == HLTH_DEGRADED) ||
                   s2_ff.temp_degr || !s2_ff.soc30 || s2_ff.vib_degr) begin
         s3_in.site_status = HLTH_DEGRADED;
      end else begin
         s3_in.site_status = HLTH_NORMAL;
      end

      case ({s3_in.site_status != HLTH_NORMAL, s2_ff.bh != BH_NORMAL})
         2'b11:   s3_in.fault_kind = KIND_MIXED;
         2'b10:   s3_in.fault_kind = KIND_LOCAL;
         2'b01:   s3_in.fault_kind = KIND_UPSTREAM;
         default: s3_in.fault_kind = KIND_NORMAL;
      endcase

      if (s2_ff.grid) begin
         s3_in.power_source = SRC_GRID;
      end else if (s2_ff.gen) begin
         s3_in.power_source = SRC_GEN;
      end else if (s2_ff.soc5) begin
         s3_in.power_source = SRC_BATTERY;
      end else begin
         s3_in.power_source = SRC_NONE;
      end

      if (s2_ff.grid && s2_ff.gen) begin
         s3_in.energy_action = ACT_STOP_GEN;
      end else if (s2_ff.grid) begin
         s3_in.energy_action = ACT_NORMAL;
      end else if (s2_ff.gen) begin
         s3_in.energy_action = ACT_GEN_SUPPLY;
      end else if (s2_ff.soc30) begin
         s3_in.energy_action = ACT_BATTERY;
      end else if (s2_ff.soc10) begin
         s3_in.energy_action = ACT_START_GEN;
      end else if (s2_ff.soc5) begin
         s3_in.energy_action = ACT_SHED;
      end else begin
         s3_in.energy_action = ACT_CRITICAL;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= req_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff <= s1_in;
      end
      if (adv2) begin
         s2_ff <= s2_in;
      end
      if (adv3) begin
         s3_ff <= s3_in;
      end
   end

endmodule
`default_nettype wire

// ===== sim/site_health_fault_classifier_tb.sv =====
// Testbench for the site health fault classifier: directed and random snapshots.
`default_nettype none
module site_health_fault_classifier_tb;
   import shfc_pkg::*;

   localparam int unsigned CODE_FS    = 4095;
   localparam int          RANDOM_REQ = 900;
   localparam int          TABLE_ROWS = 26;
   localparam int          MAX_GAP    = 14;

   // One directed request; the expected health is typed in only where it is obvious
   typedef struct packed {
      req_type snap;
      logic    known;
      rsp_type want;
   } table_row_type;

   localparam rsp_type ANY_HEALTH = '0;

   // Columns: volts, amps, battery, fwd, refl, latency, loss, rssi, temp, vibration, flags
   localparam table_row_type DIRECTED [TABLE_ROWS] = '{
      // all zero: no RF, no power, link down
      '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 'h00}, 1'b1,
        '{RF_SEVERE, HLTH_FAULT, BH_OUTAGE, HLTH_FAULT, KIND_MIXED, SRC_NONE, ACT_CRITICAL}},
      // every field all ones
      '{'{4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, -1, 65535, 'h7F}, 1'b1,
        '{RF_SEVERE, HLTH_FAULT, BH_CRITICAL, HLTH_FAULT, KIND_MIXED, SRC_GRID, ACT_STOP_GEN}},
      // healthy site on grid
      '{'{3300, 1000, 3800, 2000, 0, 0, 0, 0, 400, 0, 'h77}, 1'b1,
        '{RF_EXCELLENT, HLTH_NORMAL, BH_NORMAL, HLTH_NORMAL, KIND_NORMAL, SRC_GRID, ACT_NORMAL}},
      // fan failed forces a site fault
      '{'{3300, 1000, 3800, 2000, 0, 0, 0, 0, 400, 0, 'h67}, 1'b1,
        '{RF_EXCELLENT, HLTH_NORMAL, BH_NORMAL, HLTH_FAULT, KIND_LOCAL, SRC_GRID, ACT_NORMAL}},
      // rectifier and radio failed
      '{'{3300, 1000, 3800, 2000, 0, 0, 0, 0, 400, 0, 'h17}, 1'b0, ANY_HEALTH},
      // VSWR edges: 1.5, just under 1.5, 2, 3, reflected equal to forward
      '{'{3300, 1000, 3800, 2500, 100, 0, 0, 0, 400, 0, 'h77}, 1'b0, ANY_HEALTH},
      '{'{3300, 1000, 3800, 2500, 99, 0, 0, 0, 400, 0, 'h77}, 1'b0, ANY_HEALTH},
      '{'{3300, 1000, 3800, 900, 100, 0, 0, 0, 400, 0, 'h77}, 1'b0, ANY_HEALTH},
      '{'{3300, 1000, 3800, 400, 100, 0, 0, 0, 400, 0, 'h77}, 1'b0, ANY_HEALTH},
      '{'{3300, 1000, 3800, 2000, 2000, 0, 0, 0, 400, 0, 'h77}, 1'b0, ANY_HEALTH},
      // bus voltage and current edges, idle current under load, bus power
      '{'{2729, 1000, 3800, 2000, 0, 0, 0, 0, 400, 0, 'h77}, 1'b0, ANY_HEALTH},
      '{'{3002, 1000, 3800, 2000, 0, 0, 0, 0, 400, 0, 'h77}, 1'b0, ANY_HEALTH},
      '{'{3959, 1000, 3800, 2000, 0, 0, 0, 0, 400, 0, 'h77}, 1'b0, ANY_HEALTH},
      '{'{3300, 3413, 3800, 2000, 0, 0, 0, 0, 400, 0, 'h77}, 1'b0, ANY_HEALTH},
      '{'{3300, 136, 3800, 2000, 0, 0, 0, 0, 400, 0, 'h77}, 1'b0, ANY_HEALTH},
      '{'{3700, 3100, 3800, 2000, 0, 0, 0, 0, 400, 0, 'h77}, 1'b0, ANY_HEALTH},
      // link down, upstream down, backhaul limits
      '{'{3300, 1000, 3800, 2000, 0, 0, 0, 0, 400, 0, 'h76}, 1'b0, ANY_HEALTH},
      '{'{3300, 1000, 3800, 2000, 0, 0, 0, 0, 400, 0, 'h75}, 1'b0, ANY_HEALTH},
      '{'{3300, 1000, 3800, 2000, 0, 2441, 0, 0, 400, 0, 'h77}, 1'b0, ANY_HEALTH},
      '{'{3300, 1000, 3800, 2000, 0, 785, 2457, 1911, 400, 0, 'h77}, 1'b0, ANY_HEALTH},
      // temperature and vibration limits
      '{'{3300, 1000, 3800, 2000, 0, 0, 0, 0, 1280, 256, 'h77}, 1'b0, ANY_HEALTH},
      '{'{3300, 1000, 3800, 2000, 0, 0, 0, 0, -880, 768, 'h77}, 1'b0, ANY_HEALTH},
      // generator only, then battery charge bands
      '{'{3300, 1000, 3100, 2000, 0, 0, 0, 0, 1040, 0, 'h7B}, 1'b0, ANY_HEALTH},
      '{'{3300, 1000, 2950, 2000, 0, 0, 0, 0, 400, 0, 'h73}, 1'b0, ANY_HEALTH},
      '{'{3300, 1000, 2900, 2000, 0, 0, 0, 0, 400, 0, 'h73}, 1'b0, ANY_HEALTH},
      '{'{3300, 1000, 2896, 2000, 0, 0, 0, 0, 400, 0, 'h73}, 1'b0, ANY_HEALTH}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_health [$];
   int      fail_count  = 0;
   int      health_seen = 0;

   site_health_fault_classifier u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Health classes of one snapshot, all limits as exact integer compares on the codes
   function automatic rsp_type classify_snapshot(req_type s);
      int unsigned     volts, amps, fwd, refl, lat, loss, rssi, vib, batt;
      longint unsigned bus_power, fs_sq;
      int              temp;
      logic            soc30, soc10, soc5, grid, gen;
      rsp_type         h;
      volts = 32'(s.bus_voltage_code);
      amps  = 32'(s.bus_current_code);
      fwd   = 32'(s.forward_code);
      refl  = 32'(s.reflected_code);
      lat   = 32'(s.latency_code);
      loss  = 32'(s.loss_code);
      rssi  = 32'(s.rssi_code);
      vib   = 32'(s.vibration_level);
      batt  = 1500 * int'(s.battery_code);
      temp  = int'(s.amp_temperature);
      grid  = s.status_flags[FLAG_GRID];
      gen   = s.status_flags[FLAG_GEN];
      soc30 = batt > 1116 * CODE_FS;
      soc10 = batt > 1072 * CODE_FS;
      soc5  = batt > 1061 * CODE_FS;
      bus_power = longint'(volts) * longint'(amps);
      fs_sq     = longint'(CODE_FS) * longint'(CODE_FS);

      // RF: reflected over forward power ratio
      if (fwd == 0 || refl >= fwd)  h.rf_health = RF_SEVERE;
      else if (25 * refl < fwd)     h.rf_health = RF_EXCELLENT;
      else if (9 * refl < fwd)      h.rf_health = RF_NORMAL;
      else if (4 * refl < fwd)      h.rf_health = RF_DEGRADED;
      else                          h.rf_health = RF_FAULT;

      // DC bus
      if (volts < 2730 || volts >= 3959 || amps >= 3413 || 3 * bus_power > 2 * fs_sq ||
          (fwd > 819 && amps <= 136))
         h.electrical_health = HLTH_FAULT;
      else if (volts < 3003 || volts >= 3754 || amps > 2730 || 2 * bus_power > fs_sq)
         h.electrical_health = HLTH_DEGRADED;
      else
         h.electrical_health = HLTH_NORMAL;

      // Backhaul
      if (!s.status_flags[FLAG_LINK] || !s.status_flags[FLAG_UPSTREAM])
         h.backhaul_state = BH_OUTAGE;
      else if (990 * lat >= 590 * CODE_FS || 100 * loss >= 60 * CODE_FS ||
               75 * rssi >= 50 * CODE_FS)
         h.backhaul_state = BH_CRITICAL;
      else if (990 * lat >= 190 * CODE_FS || 100 * loss >= 10 * CODE_FS ||
               75 * rssi >= 35 * CODE_FS)
         h.backhaul_state = BH_DEGRADED;
      else
         h.backhaul_state = BH_NORMAL;

      // Local site; any failed equipment flag wins
      if (h.rf_health >= RF_FAULT || h.electrical_health == HLTH_FAULT || temp >= 1280 ||
          vib >= 768)
         h.site_status = HLTH_FAULT;
      else if (h.rf_health == RF_DEGRADED || h.electrical_health == HLTH_DEGRADED ||
               temp >= 1040 || !soc30 || vib >= 256)
         h.site_status = HLTH_DEGRADED;
      else
         h.site_status = HLTH_NORMAL;
      if (!s.status_flags[FLAG_FAN] || !s.status_flags[FLAG_RECT] ||
          !s.status_flags[FLAG_RADIO])
         h.site_status = HLTH_FAULT;

      if (h.site_status != HLTH_NORMAL && h.backhaul_state != BH_NORMAL)
         h.fault_kind = KIND_MIXED;
      else if (h.site_status != HLTH_NORMAL)
         h.fault_kind = KIND_LOCAL;
      else if (h.backhaul_state != BH_NORMAL)
         h.fault_kind = KIND_UPSTREAM;
      else
         h.fault_kind = KIND_NORMAL;

      // Power source and energy action
      if (grid)       h.power_source = SRC_GRID;
      else if (gen)   h.power_source = SRC_GEN;
      else if (soc5)  h.power_source = SRC_BATTERY;
      else            h.power_source = SRC_NONE;

      if (grid && gen)  h.energy_action = ACT_STOP_GEN;
      else if (grid)    h.energy_action = ACT_NORMAL;
      else if (gen)     h.energy_action = ACT_GEN_SUPPLY;
      else if (soc30)   h.energy_action = ACT_BATTERY;
      else if (soc10)   h.energy_action = ACT_START_GEN;
      else if (soc5)    h.energy_action = ACT_SHED;
      else              h.energy_action = ACT_CRITICAL;
      return h;
   endfunction

   // Code a few steps either side of a limit, clipped to the converter range
   function automatic logic [11:0] code_near(int center, int spread);
      int x;
      x = center - spread + int'($urandom_range(0, 2 * spread));
      if (x < 0)    x = 0;
      if (x > 4095) x = 4095;
      return 12'(x);
   endfunction

   // Mostly inside a band or at its edges, sometimes anywhere
   function automatic logic [11:0] code_band(int lo, int hi);
      case ($urandom_range(0, 5))
         0:       return 12'($urandom_range(0, 4095));
         1:       return code_near(lo, 3);
         2:       return code_near(hi, 3);
         default: return 12'($urandom_range(lo, hi));
      endcase
   endfunction

   function automatic req_type random_snapshot();
      req_type s;
      int      ratio;
      s.bus_voltage_code = $urandom_range(0, 1) ? code_band(3003, 3754) : code_band(2730, 3959);
      s.bus_current_code = $urandom_range(0, 1) ? code_band(136, 2730) : code_band(2730, 3413);
      s.battery_code     = code_band(2897, 3047);
      s.latency_code     = $urandom_range(0, 2) == 0 ? code_band(786, 2441) : code_band(0, 786);
      s.loss_code        = $urandom_range(0, 2) == 0 ? code_band(410, 2457) : code_band(0, 410);
      s.rssi_code        = $urandom_range(0, 2) == 0 ? code_band(1911, 2730) : code_band(0, 1911);

      // RF pair built around the VSWR ratios
      s.forward_code = $urandom_range(0, 3) == 0 ? code_near(819, 4) :
                                                   12'($urandom_range(1, 4095));
      case ($urandom_range(0, 4))
         0:       ratio = 25;
         1:       ratio = 9;
         2:       ratio = 4;
         3:       ratio = 1;
         default: ratio = 0;
      endcase
      if (ratio == 0) s.reflected_code = 12'($urandom_range(0, 4095));
      else            s.reflected_code = code_near(int'(s.forward_code) / ratio, 2);
      if ($urandom_range(0, 31) == 0) s.forward_code = '0;

      case ($urandom_range(0, 4))
         0:       s.amp_temperature = 12'(int'($urandom_range(0, 2880)) - 880);
         1:       s.amp_temperature = 12'(1276 + int'($urandom_range(0, 8)));
         2:       s.amp_temperature = 12'(1036 + int'($urandom_range(0, 8)));
         default: s.amp_temperature = 12'($urandom_range(0, 1000));
      endcase
      case ($urandom_range(0, 4))
         0:       s.vibration_level = 16'($urandom_range(0, 65535));
         1:       s.vibration_level = 16'($urandom_range(252, 260));
         2:       s.vibration_level = 16'($urandom_range(764, 772));
         default: s.vibration_level = 16'($urandom_range(0, 700));
      endcase

      // Equipment mostly good and link mostly up
      if ($urandom_range(0, 3) == 0) begin
         s.status_flags = 7'($urandom_range(0, 127));
      end else begin
         s.status_flags = {3'b111, 4'($urandom_range(0, 15))};
         if ($urandom_range(0, 3) != 0) s.status_flags[1:0] = 2'b11;
      end
      return s;
   endfunction

   task automatic report_field(string field, int want, int got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count++;
   endtask

   task automatic check_health(rsp_type got);
      rsp_type want;
      if (expected_health.size() == 0) begin
         $display("%0t: response with no request pending, got %h", $time, got);
         fail_count++;
         return;
      end
      want = expected_health.pop_front();
      if (got.rf_health !== want.rf_health)
         report_field("rf_health", int'(want.rf_health), int'(got.rf_health));
      if (got.electrical_health !== want.electrical_health)
         report_field("electrical_health", int'(want.electrical_health),
                      int'(got.electrical_health));
      if (got.backhaul_state !== want.backhaul_state)
         report_field("backhaul_state", int'(want.backhaul_state), int'(got.backhaul_state));
      if (got.site_status !== want.site_status)
         report_field("site_status", int'(want.site_status), int'(got.site_status));
      if (got.fault_kind !== want.fault_kind)
         report_field("fault_kind", int'(want.fault_kind), int'(got.fault_kind));
      if (got.power_source !== want.power_source)
         report_field("power_source", int'(want.power_source), int'(got.power_source));
      if (got.energy_action !== want.energy_action)
         report_field("energy_action", int'(want.energy_action), int'(got.energy_action));
   endtask

   // Offer one request after an idle gap; called at a falling edge, returns at one
   task automatic offer_snapshot(req_type snap, rsp_type want, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= snap;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_health.push_back(want);
      @(negedge clock);
   endtask

   // Request side: reset, directed table, then random snapshots
   initial begin : request_side
      req_type snap;
      rsp_type want;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < TABLE_ROWS; i++) begin
         want = DIRECTED[i].known ? DIRECTED[i].want : classify_snapshot(DIRECTED[i].snap);
         offer_snapshot(DIRECTED[i].snap, want, int'($urandom_range(0, MAX_GAP)));
      end

      // back-to-back stretches every 200 requests
      for (int i = 0; i < RANDOM_REQ; i++) begin
         snap = random_snapshot();
         offer_snapshot(snap, classify_snapshot(snap),
                        (i % 200 >= 140) ? 0 : int'($urandom_range(0, MAX_GAP)));
      end
      req_valid <= 1'b0;

      // drain, then let the pipeline settle before the verdict
      while (expected_health.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Response side: random stalls, open stretches, and one long hold-off
   initial begin : response_side
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (health_seen == 300)
            stall = 90;
         else if (health_seen % 170 >= 120)
            stall = 0;
         else
            stall = int'($urandom_range(0, MAX_GAP));
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         check_health(rsp_data);
         health_seen++;
         @(negedge clock);
      end
   end

   initial begin : watchdog
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire
